FILE: hw/rtl/plt_pkg.sv
// types and constants shared by the lightness tone curve pipeline
`timescale 1ns / 1ps

package plt_pkg;

   localparam int PIX_W = 8;
   localparam int NUM_W = 17;
   localparam int DEN_W = 9;
   localparam int OFS_W = 9;
   localparam int CSR_IDX_W = 1;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 1'b1;

   localparam logic MODE_INVERT = 1'b0;
   localparam logic MODE_CURVE = 1'b1;

   typedef enum logic [1:0] {
      KIND_DIRECT,
      KIND_QUO,
      KIND_INV_QUO
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [PIX_W-1:0] direct;
      logic [DEN_W-1:0] mul_a;
      logic [PIX_W-1:0] mul_b;
      logic [DEN_W-1:0] den;
      logic             ceil_add;
   } prep_type;

   typedef struct packed {
      kind_type         kind;
      logic [PIX_W-1:0] direct;
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [PIX_W-1:0] quo;
   } div_type;

endpackage

FILE: hw/rtl/plt_prep.sv
// first stage: knee position, segment select and divider operands
`timescale 1ns / 1ps

module plt_prep (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic                       in_valid,
   input  logic [plt_pkg::PIX_W-1:0]  pixel,
   input  logic                       mode,
   input  logic [plt_pkg::OFS_W-1:0]  offset,
   output logic                       out_valid_ff,
   output plt_pkg::prep_type          out_ff
);
   import plt_pkg::*;

   logic signed [10:0] h_ext;
   logic signed [10:0] x2_s;
   logic signed [10:0] y2_s;
   logic [9:0]         x2;
   logic [9:0]         y2;
   logic [9:0]         v2;
   prep_type           out_in;

   always_comb begin
      // most negative code saturates to -255
      if (offset == 9'h100) begin
         h_ext = -11'sd255;
      end else begin
         h_ext = 11'(signed'(offset));
      end
      x2_s = 11'sd255 + h_ext;
      y2_s = 11'sd255 - h_ext;
      x2 = x2_s[9:0];
      y2 = y2_s[9:0];
      v2 = {1'b0, pixel, 1'b0};

      out_in.kind = KIND_DIRECT;
      out_in.direct = '0;
      out_in.mul_a = '0;
      out_in.mul_b = '0;
      out_in.den = DEN_W'(1);
      out_in.ceil_add = 1'b0;

      if (mode == MODE_INVERT) begin
         out_in.direct = PIX_MAX - pixel;
      end else if (x2 == '0) begin
         out_in.direct = PIX_MAX;
      end else if (y2 == '0) begin
         out_in.direct = '0;
      end else if (v2 == x2) begin
         out_in.direct = y2[8:1];
      end else if (v2 < x2) begin
         // rising segment: y2*v / x2
         out_in.kind = KIND_QUO;
         out_in.mul_a = y2[DEN_W-1:0];
         out_in.mul_b = pixel;
         out_in.den = x2[DEN_W-1:0];
      end else begin
         // upper segment: 255 - ceil(x2*(255-v) / y2)
         out_in.kind = KIND_INV_QUO;
         out_in.mul_a = x2[DEN_W-1:0];
         out_in.mul_b = PIX_MAX - pixel;
         out_in.den = y2[DEN_W-1:0];
         out_in.ceil_add = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: hw/rtl/plt_mult.sv
// second stage: numerator product with rounding bias
`timescale 1ns / 1ps

module plt_mult (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              in_valid,
   input  plt_pkg::prep_type in_data,
   output logic              out_valid_ff,
   output plt_pkg::div_type  out_ff
);
   import plt_pkg::*;

   logic [NUM_W-1:0] prod;
   logic [NUM_W-1:0] bias;
   div_type          out_in;

   always_comb begin
      prod = NUM_W'(in_data.mul_a) * NUM_W'(in_data.mul_b);
      // den - 1 turns the floor division into a ceiling
      bias = in_data.ceil_add ? (NUM_W'(in_data.den) - NUM_W'(1)) : '0;
      out_in.kind = in_data.kind;
      out_in.direct = in_data.direct;
      out_in.rem = prod + bias;
      out_in.den = in_data.den;
      out_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: hw/rtl/plt_div_step.sv
// restoring divider stage, two quotient bits per stage
`timescale 1ns / 1ps

module plt_div_step #(
   parameter int BIT_HI = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             in_valid,
   input  plt_pkg::div_type in_data,
   output logic             out_valid_ff,
   output plt_pkg::div_type out_ff
);
   import plt_pkg::*;

   localparam int BIT_LO = BIT_HI - 1;

   logic [NUM_W-1:0] d_hi;
   logic [NUM_W-1:0] d_lo;
   logic [NUM_W-1:0] rem_mid;
   div_type          out_in;

   always_comb begin
      d_hi = NUM_W'(in_data.den) << BIT_HI;
      d_lo = NUM_W'(in_data.den) << BIT_LO;
      out_in = in_data;

      rem_mid = in_data.rem;
      if (in_data.rem >= d_hi) begin
         rem_mid = in_data.rem - d_hi;
         out_in.quo[BIT_HI] = 1'b1;
      end

      out_in.rem = rem_mid;
      if (rem_mid >= d_lo) begin
         out_in.rem = rem_mid - d_lo;
         out_in.quo[BIT_LO] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: hw/rtl/pixel_lightness_tone_curve.sv
// top level of the pixel lightness tone curve pipeline
`timescale 1ns / 1ps

//  channel   direction   signals                               word
//  req       in          req_valid req_ready req_pixel_in      one 8-bit channel value
//  rsp       out         rsp_valid rsp_ready rsp_pixel_out     one mapped 8-bit value
//  csr       in          csr_wr_en csr_index csr_wdata         register write, no wait
//
//  seven register stages: prep, multiply, four divider stages, output register
//  one word per cycle sustained while rsp_ready is held high
//  the divider retires two quotient bits per stage
//  each stage moves when it is empty or the stage after it moves, so bubbles
//  fill up behind a stalled output; reset clears all valid bits and the csrs
//  reset values: mode selects the curve, offset zero

module pixel_lightness_tone_curve (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [plt_pkg::PIX_W-1:0]    req_pixel_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [plt_pkg::PIX_W-1:0]    rsp_pixel_out,
   input  logic                         csr_wr_en,
   input  logic [plt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [plt_pkg::OFS_W-1:0]    csr_wdata
);
   import plt_pkg::*;

   localparam int DIV_STAGES = 4;

   // configuration registers
   logic             mode_ff;
   logic [OFS_W-1:0] offset_ff;

   // stage handshake
   logic                  prep_valid;
   prep_type              prep_data;
   logic                  prep_en;
   logic                  mult_valid;
   div_type               mult_data;
   logic                  mult_en;
   logic [DIV_STAGES-1:0] div_valid;
   div_type               div_data [DIV_STAGES];
   logic [DIV_STAGES-1:0] div_en;
   logic                  out_en;

   // output register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic [PIX_W-1:0] rsp_pixel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CURVE;
         offset_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE: begin
               mode_ff <= csr_wdata[0];
            end
            CSR_OFFSET: begin
               offset_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // enable chain, back from the output register
   always_comb begin
      out_en = !rsp_valid_ff || rsp_ready;
      div_en[DIV_STAGES-1] = !div_valid[DIV_STAGES-1] || out_en;
      for (int i = DIV_STAGES - 2; i >= 0; i--) begin
         div_en[i] = !div_valid[i] || div_en[i+1];
      end
      mult_en = !mult_valid || div_en[0];
      prep_en = !prep_valid || mult_en;
   end

   assign req_ready = prep_en;

   plt_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .load         (prep_en),
      .in_valid     (req_valid),
      .pixel        (req_pixel_in),
      .mode         (mode_ff),
      .offset       (offset_ff),
      .out_valid_ff (prep_valid),
      .out_ff       (prep_data)
   );

   plt_mult u_mult (
      .clock        (clock),
      .reset        (reset),
      .load         (mult_en),
      .in_valid     (prep_valid),
      .in_data      (prep_data),
      .out_valid_ff (mult_valid),
      .out_ff       (mult_data)
   );

   // quotient fits eight bits on both segments, so bits 7 down to 0 suffice
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      if (g == 0) begin : g_first
         plt_div_step #(
            .BIT_HI (PIX_W - 1)
         ) u_step (
            .clock        (clock),
            .reset        (reset),
            .load         (div_en[g]),
            .in_valid     (mult_valid),
            .in_data      (mult_data),
            .out_valid_ff (div_valid[g]),
            .out_ff       (div_data[g])
         );
      end else begin : g_rest
         plt_div_step #(
            .BIT_HI (PIX_W - 1 - 2 * g)
         ) u_step (
            .clock        (clock),
            .reset        (reset),
            .load         (div_en[g]),
            .in_valid     (div_valid[g-1]),
            .in_data      (div_data[g-1]),
            .out_valid_ff (div_valid[g]),
            .out_ff       (div_data[g])
         );
      end
   end

   // pick the direct value, the quotient, or its mirror from 255
   always_comb begin
      case (div_data[DIV_STAGES-1].kind)
         KIND_QUO: begin
            rsp_pixel_in = div_data[DIV_STAGES-1].quo;
         end
         KIND_INV_QUO: begin
            rsp_pixel_in = PIX_MAX - div_data[DIV_STAGES-1].quo;
         end
         default: begin
            rsp_pixel_in = div_data[DIV_STAGES-1].direct;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= div_valid[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

endmodule
